>>> rtl/integer_pixel_replication_upscaler_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the integer pixel replication upscaler
// Clocked implication checks with reset disable, same and next cycle forms.
// ----------------------------------------------------------------------------
`ifndef INTEGER_PIXEL_REPLICATION_UPSCALER_ASSERT_SVH
`define INTEGER_PIXEL_REPLICATION_UPSCALER_ASSERT_SVH

// Antecedent implies consequent in the same cycle.
`define IPRU_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ipru assertion failed");

// Antecedent implies consequent in the next cycle.
`define IPRU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ipru assertion failed");

`endif

>>> rtl/ipru_pkg.sv
// ----------------------------------------------------------------------------
// ipru_pkg
// Shared types and constants of the integer pixel replication upscaler.
// ----------------------------------------------------------------------------
`default_nettype none

package ipru_pkg;

    localparam int CFG_DIM_W   = 7;
    localparam int CFG_SCALE_W = 5;
    localparam int PIXEL_W     = 8;
    localparam int CMD_W       = 2;
    localparam int APB_DATA_W  = 32;
    localparam int APB_ADDR_W  = 4;
    localparam int REG_IDX_W   = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD    = 2'd0,
        CMD_PULL    = 2'd1,
        CMD_RESTART = 2'd2,
        CMD_NOP     = 2'd3
    } t_command;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_IMAGE_ROWS = 2'd0,
        REG_IMAGE_COLS = 2'd1,
        REG_ROW_SCALE  = 2'd2,
        REG_COL_SCALE  = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [CFG_DIM_W-1:0]   image_rows;
        logic [CFG_DIM_W-1:0]   image_cols;
        logic [CFG_SCALE_W-1:0] row_scale;
        logic [CFG_SCALE_W-1:0] col_scale;
    } t_cfg;

    // controller -> datapath
    typedef struct packed {
        logic load_we;
        logic restart;
        logic pull;
        logic out_load;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic load_full;
    } t_dp_status;

endpackage

`default_nettype wire

>>> rtl/ipru_if.sv
// ----------------------------------------------------------------------------
// ipru channel interfaces
// Valid/ready channels for command items and result pixels.
// ----------------------------------------------------------------------------
`default_nettype none

interface ipru_in_if;
    import ipru_pkg::*;
    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   command;
    logic [PIXEL_W-1:0] pixel_in;

    modport source (output valid, command, pixel_in, input ready);
    modport sink   (input valid, command, pixel_in, output ready);
endinterface

interface ipru_out_if;
    import ipru_pkg::*;
    logic               valid;
    logic               ready;
    logic [PIXEL_W-1:0] pixel_out;
    logic               line_end;
    logic               frame_end;

    modport source (output valid, pixel_out, line_end, frame_end, input ready);
    modport sink   (input valid, pixel_out, line_end, frame_end, output ready);
endinterface

`default_nettype wire

>>> rtl/ipru_regs.sv
// ----------------------------------------------------------------------------
// ipru_regs
// APB register file: image size and scale factors, reset to 1.
// ----------------------------------------------------------------------------
`default_nettype none

module ipru_regs
    import ipru_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    output t_cfg                       o_cfg
);

    t_cfg     r_cfg, n_cfg;
    t_reg_idx reg_idx;
    logic     wr_en;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = t_reg_idx'(paddr[APB_ADDR_W-1:2]);

    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            unique case (reg_idx)
                REG_IMAGE_ROWS: n_cfg.image_rows = pwdata[CFG_DIM_W-1:0];
                REG_IMAGE_COLS: n_cfg.image_cols = pwdata[CFG_DIM_W-1:0];
                REG_ROW_SCALE:  n_cfg.row_scale  = pwdata[CFG_SCALE_W-1:0];
                REG_COL_SCALE:  n_cfg.col_scale  = pwdata[CFG_SCALE_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_IMAGE_ROWS: prdata = APB_DATA_W'(r_cfg.image_rows);
            REG_IMAGE_COLS: prdata = APB_DATA_W'(r_cfg.image_cols);
            REG_ROW_SCALE:  prdata = APB_DATA_W'(r_cfg.row_scale);
            REG_COL_SCALE:  prdata = APB_DATA_W'(r_cfg.col_scale);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.image_rows <= CFG_DIM_W'(1);
            r_cfg.image_cols <= CFG_DIM_W'(1);
            r_cfg.row_scale  <= CFG_SCALE_W'(1);
            r_cfg.col_scale  <= CFG_SCALE_W'(1);
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

>>> rtl/ipru_ctrl.sv
// ----------------------------------------------------------------------------
// ipru_ctrl
// Command decode, frame store read sequencing and output register handshake.
// ----------------------------------------------------------------------------
`default_nettype none
`include "integer_pixel_replication_upscaler_assert.svh"

module ipru_ctrl
    import ipru_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire logic [CMD_W-1:0] i_command,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output t_dp_cmd               o_cmd,
    input  wire t_dp_status       i_status
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_READ = 2'b10
    } t_state;

    t_state   r_state, n_state;
    logic     r_out_valid, n_out_valid;
    logic     in_accept;
    logic     out_free;
    t_command cmd_code;

    assign cmd_code   = t_command'(i_command);
    assign o_in_ready = (r_state == S_IDLE);
    assign in_accept  = i_in_valid & o_in_ready;
    assign out_free   = ~r_out_valid | i_out_ready;

    always_comb begin
        o_cmd.load_we  = in_accept && (cmd_code == CMD_LOAD) && !i_status.load_full;
        o_cmd.restart  = in_accept && (cmd_code == CMD_RESTART);
        o_cmd.pull     = in_accept && (cmd_code == CMD_PULL);
        o_cmd.out_load = (r_state == S_READ) && out_free;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (o_cmd.pull) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        priority if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    `IPRU_ASSERT_NEXT(a_pull_enters_read, i_clk, i_rst_n, o_cmd.pull, r_state == S_READ)
    `IPRU_ASSERT_NEXT(a_load_shows_result, i_clk, i_rst_n, o_cmd.out_load, r_out_valid)
    `IPRU_ASSERT_NEXT(a_read_waits_on_stall, i_clk, i_rst_n,
        (r_state == S_READ) && r_out_valid && !i_out_ready,
        (r_state == S_READ) && r_out_valid)
    `IPRU_ASSERT_SAME(a_no_accept_in_read, i_clk, i_rst_n,
        r_state == S_READ, !o_cmd.pull && !o_cmd.load_we && !o_cmd.restart)

endmodule

`default_nettype wire

>>> rtl/ipru_datapath.sv
// ----------------------------------------------------------------------------
// ipru_datapath
// Frame store, load and output position counters, result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module ipru_datapath
    import ipru_pkg::*;
#(
    parameter int MAX_ROWS  = 64,
    parameter int MAX_COLS  = 64,
    parameter int MAX_SCALE = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_cfg               i_cfg,
    input  wire t_dp_cmd            i_cmd,
    output t_dp_status              o_status,
    input  wire logic [PIXEL_W-1:0] i_pixel_in,
    output logic      [PIXEL_W-1:0] o_pixel_out,
    output logic                    o_line_end,
    output logic                    o_frame_end
);

    // index widths
    localparam int ROW_IW = (MAX_ROWS  > 1) ? $clog2(MAX_ROWS)  : 1;
    localparam int COL_IW = (MAX_COLS  > 1) ? $clog2(MAX_COLS)  : 1;
    localparam int SCL_IW = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1;
    // load row counts up to the row limit itself
    localparam int ROW_CW = $clog2(MAX_ROWS + 1);
    // compare widths, wide enough for both register and maximum
    localparam int ROW_LW = (ROW_CW > CFG_DIM_W) ? ROW_CW : CFG_DIM_W;
    localparam int COL_CW = $clog2(MAX_COLS + 1);
    localparam int COL_LW = (COL_CW > CFG_DIM_W) ? COL_CW : CFG_DIM_W;
    localparam int SCL_CW = $clog2(MAX_SCALE + 1);
    localparam int SCL_LW = (SCL_CW > CFG_SCALE_W) ? SCL_CW : CFG_SCALE_W;
    localparam int DEPTH  = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // ---------------- effective limits (0 acts as 1, clip to maximum)
    logic [ROW_LW-1:0] rows_raw, rows_lim;
    logic [COL_LW-1:0] cols_raw, cols_lim;
    logic [SCL_LW-1:0] rs_raw, rs_lim, cs_raw, cs_lim;

    assign rows_raw = ROW_LW'(i_cfg.image_rows);
    assign cols_raw = COL_LW'(i_cfg.image_cols);
    assign rs_raw   = SCL_LW'(i_cfg.row_scale);
    assign cs_raw   = SCL_LW'(i_cfg.col_scale);

    always_comb begin
        priority if (rows_raw == '0)                   rows_lim = ROW_LW'(1);
        else if (rows_raw > ROW_LW'(MAX_ROWS))         rows_lim = ROW_LW'(MAX_ROWS);
        else                                           rows_lim = rows_raw;
        priority if (cols_raw == '0)                   cols_lim = COL_LW'(1);
        else if (cols_raw > COL_LW'(MAX_COLS))         cols_lim = COL_LW'(MAX_COLS);
        else                                           cols_lim = cols_raw;
        priority if (rs_raw == '0)                     rs_lim = SCL_LW'(1);
        else if (rs_raw > SCL_LW'(MAX_SCALE))          rs_lim = SCL_LW'(MAX_SCALE);
        else                                           rs_lim = rs_raw;
        priority if (cs_raw == '0)                     cs_lim = SCL_LW'(1);
        else if (cs_raw > SCL_LW'(MAX_SCALE))          cs_lim = SCL_LW'(MAX_SCALE);
        else                                           cs_lim = cs_raw;
    end

    // ---------------- position counters
    logic [ROW_CW-1:0] r_load_row, n_load_row;
    logic [COL_IW-1:0] r_load_col, n_load_col;
    logic [ROW_IW-1:0] r_out_row,  n_out_row;
    logic [SCL_IW-1:0] r_out_rrep, n_out_rrep;
    logic [COL_IW-1:0] r_out_col,  n_out_col;
    logic [SCL_IW-1:0] r_out_crep, n_out_crep;

    // load side
    logic [COL_IW-1:0] ld_col;
    logic              ld_col_last;
    logic [ADDR_W-1:0] wr_addr;

    assign o_status.load_full = (ROW_LW'(r_load_row) >= rows_lim);
    assign ld_col      = (COL_LW'(r_load_col) >= cols_lim) ? '0 : r_load_col;
    assign ld_col_last = (COL_LW'(ld_col) + COL_LW'(1)) >= cols_lim;
    assign wr_addr     = ADDR_W'(ROW_IW'(r_load_row)) * ADDR_W'(MAX_COLS)
                       + ADDR_W'(ld_col);

    // output side, stale positions fold to zero
    logic [ROW_IW-1:0] pr_row;
    logic [SCL_IW-1:0] pr_rrep, pr_crep;
    logic [COL_IW-1:0] pr_col;
    logic              row_last, rrep_last, col_last, crep_last;
    logic              line_end, frame_end;
    logic [ADDR_W-1:0] rd_addr;

    assign pr_row  = (ROW_LW'(r_out_row)  >= rows_lim) ? '0 : r_out_row;
    assign pr_rrep = (SCL_LW'(r_out_rrep) >= rs_lim)   ? '0 : r_out_rrep;
    assign pr_col  = (COL_LW'(r_out_col)  >= cols_lim) ? '0 : r_out_col;
    assign pr_crep = (SCL_LW'(r_out_crep) >= cs_lim)   ? '0 : r_out_crep;

    assign row_last  = (ROW_LW'(pr_row)  + ROW_LW'(1)) >= rows_lim;
    assign rrep_last = (SCL_LW'(pr_rrep) + SCL_LW'(1)) >= rs_lim;
    assign col_last  = (COL_LW'(pr_col)  + COL_LW'(1)) >= cols_lim;
    assign crep_last = (SCL_LW'(pr_crep) + SCL_LW'(1)) >= cs_lim;

    assign line_end  = col_last & crep_last;
    assign frame_end = line_end & row_last & rrep_last;
    assign rd_addr   = ADDR_W'(pr_row) * ADDR_W'(MAX_COLS) + ADDR_W'(pr_col);

    always_comb begin
        n_load_row = r_load_row;
        n_load_col = r_load_col;
        n_out_row  = r_out_row;
        n_out_rrep = r_out_rrep;
        n_out_col  = r_out_col;
        n_out_crep = r_out_crep;
        priority if (i_cmd.restart) begin
            n_load_row = '0;
            n_load_col = '0;
            n_out_row  = '0;
            n_out_rrep = '0;
            n_out_col  = '0;
            n_out_crep = '0;
        end else if (i_cmd.load_we) begin
            if (ld_col_last) begin
                n_load_col = '0;
                n_load_row = r_load_row + ROW_CW'(1);
            end else begin
                n_load_col = ld_col + COL_IW'(1);
            end
        end else if (i_cmd.pull) begin
            // odometer: column repeat, column, row repeat, row
            n_out_crep = crep_last ? '0 : pr_crep + SCL_IW'(1);
            n_out_col  = pr_col;
            n_out_rrep = pr_rrep;
            n_out_row  = pr_row;
            if (crep_last) begin
                n_out_col = col_last ? '0 : pr_col + COL_IW'(1);
                if (col_last) begin
                    n_out_rrep = rrep_last ? '0 : pr_rrep + SCL_IW'(1);
                    if (rrep_last) begin
                        n_out_row = row_last ? '0 : pr_row + ROW_IW'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_row <= '0;
            r_load_col <= '0;
            r_out_row  <= '0;
            r_out_rrep <= '0;
            r_out_col  <= '0;
            r_out_crep <= '0;
        end else begin
            r_load_row <= n_load_row;
            r_load_col <= n_load_col;
            r_out_row  <= n_out_row;
            r_out_rrep <= n_out_rrep;
            r_out_col  <= n_out_col;
            r_out_crep <= n_out_crep;
        end
    end

    // ---------------- frame store, one write or one registered read per cycle
    logic [PIXEL_W-1:0] r_frame [DEPTH];
    logic [PIXEL_W-1:0] r_rd_data;
    logic               r_rd_lend, r_rd_fend;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_we) begin
            r_frame[wr_addr] <= i_pixel_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pull) begin
            r_rd_data <= r_frame[rd_addr];
            r_rd_lend <= line_end;
            r_rd_fend <= frame_end;
        end
    end

    // ---------------- result register
    logic [PIXEL_W-1:0] r_pixel_out;
    logic               r_line_end, r_frame_end;

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_pixel_out <= r_rd_data;
            r_line_end  <= r_rd_lend;
            r_frame_end <= r_rd_fend;
        end
    end

    assign o_pixel_out = r_pixel_out;
    assign o_line_end  = r_line_end;
    assign o_frame_end = r_frame_end;

endmodule

`default_nettype wire

>>> rtl/integer_pixel_replication_upscaler.sv
// ----------------------------------------------------------------------------
// integer_pixel_replication_upscaler
// Nearest-neighbor integer upscaler: loads a source image into a frame store
// and streams the enlarged image one pixel per pull command.
// ----------------------------------------------------------------------------
//
//  channel   dir   handshake          payload
//  i_pix     in    valid / ready      command, pixel_in
//  o_res     out   valid / ready      pixel_out, line_end, frame_end
//  apb       in    psel / penable     paddr, pwdata -> prdata (pready tied high)
//
//  Load, restart and unused commands are taken in the idle state; a pull
//  reads the frame store through its registered read port, then transfers
//  into the result register, and the input stays not ready until it has.
//  A finished pixel waits in the result register while further loads and
//  restarts are taken; a pull stalls in its read cycle until that register frees.
//  Synchronous active-low reset clears positions, handshake state and config
//  (all registers read 1); frame store contents are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module integer_pixel_replication_upscaler
    import ipru_pkg::*;
#(
    parameter int MAX_ROWS  = 64,
    parameter int MAX_COLS  = 64,
    parameter int MAX_SCALE = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // configuration
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    // streams
    ipru_in_if.sink                    i_pix,
    ipru_out_if.source                 o_res
);

    t_cfg       cfg;
    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    // register file; the user must write it only while the block is idle, the block itself does not enforce it
    ipru_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // controller: decodes each transfer, sequences the read, owns o_res.valid
    ipru_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_pix.valid),
        .o_in_ready  (i_pix.ready),
        .i_command   (i_pix.command),
        .o_out_valid (o_res.valid),
        .i_out_ready (o_res.ready),
        .o_cmd       (dp_cmd),
        .i_status    (dp_status)
    );

    // datapath: frame store, position counters, result payload
    ipru_datapath #(
        .MAX_ROWS  (MAX_ROWS),
        .MAX_COLS  (MAX_COLS),
        .MAX_SCALE (MAX_SCALE)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_cmd       (dp_cmd),
        .o_status    (dp_status),
        .i_pixel_in  (i_pix.pixel_in),
        .o_pixel_out (o_res.pixel_out),
        .o_line_end  (o_res.line_end),
        .o_frame_end (o_res.frame_end)
    );

endmodule

`default_nettype wire

>>> tb/sv/upscale_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// upscale_checker
// Watches the register port and both streams of the upscaler, keeps its own
// frame store, scan position and register copy, predicts every output pixel
// and compares each result transfer with the oldest open prediction.
// ----------------------------------------------------------------------------

module upscale_checker
    import ipru_pkg::*;
#(
    parameter int MAX_ROWS     = 64,
    parameter int MAX_COLS     = 64,
    parameter int MAX_SCALE    = 16,
    parameter int REPORT_LIMIT = 10
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_psel,
    input  wire logic                  i_penable,
    input  wire logic                  i_pwrite,
    input  wire logic                  i_pready,
    input  wire logic [APB_ADDR_W-1:0] i_paddr,
    input  wire logic [APB_DATA_W-1:0] i_pwdata,
    input  wire logic [APB_DATA_W-1:0] i_prdata,
    ipru_in_if                         i_pix_mon,
    ipru_out_if                        i_res_mon,
    output int                         o_mismatches,
    output int                         o_pending,
    output int                         o_pixels,
    output int                         o_frames
);

    typedef struct packed {
        logic [PIXEL_W-1:0] pixel;
        logic               line_end;
        logic               frame_end;
    } t_out_pixel;

    t_out_pixel pixel_expect_q[$];

    logic [PIXEL_W-1:0]     frame_copy [MAX_ROWS*MAX_COLS];
    logic [CFG_DIM_W-1:0]   rows_reg, cols_reg;
    logic [CFG_SCALE_W-1:0] rscale_reg, cscale_reg;

    // load position, then scan position of the enlarged frame
    logic [6:0] ld_row;
    logic [5:0] ld_col;
    logic [5:0] scan_row, scan_col;
    logic [3:0] scan_rrep, scan_crep;

    int mismatch_count;
    int pixel_count;
    int frame_count;

    function automatic int fit_range(input int v, input int hi);
        if (v == 0) return 1;
        return (v > hi) ? hi : v;
    endfunction

    function automatic void flag_error(input string msg);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) $display("upscale_checker: %s", msg);
    endfunction

    task automatic upscale_step(input t_command cmd, input logic [PIXEL_W-1:0] pix);
        int         rows, cols, rs, cs;
        t_out_pixel nxt;
        rows = fit_range(int'(rows_reg), MAX_ROWS);
        cols = fit_range(int'(cols_reg), MAX_COLS);
        rs   = fit_range(int'(rscale_reg), MAX_SCALE);
        cs   = fit_range(int'(cscale_reg), MAX_SCALE);
        case (cmd)
            CMD_LOAD: begin
                if (ld_row < rows) begin
                    if (ld_col >= cols) ld_col = '0;
                    frame_copy[ld_row * MAX_COLS + ld_col] = pix;
                    if (ld_col + 1 >= cols) begin
                        ld_col = '0;
                        ld_row++;
                    end else begin
                        ld_col++;
                    end
                end
            end
            CMD_RESTART: begin
                ld_row    = '0;
                ld_col    = '0;
                scan_row  = '0;
                scan_rrep = '0;
                scan_col  = '0;
                scan_crep = '0;
            end
            CMD_PULL: begin
                // counters left beyond a shrunken limit restart at zero
                if (scan_row >= rows) scan_row = '0;
                if (scan_rrep >= rs) scan_rrep = '0;
                if (scan_col >= cols) scan_col = '0;
                if (scan_crep >= cs) scan_crep = '0;
                nxt.pixel     = frame_copy[scan_row * MAX_COLS + scan_col];
                nxt.line_end  = (scan_col + 1 >= cols) && (scan_crep + 1 >= cs);
                nxt.frame_end = nxt.line_end && (scan_row + 1 >= rows)
                                && (scan_rrep + 1 >= rs);
                pixel_expect_q.insert(pixel_expect_q.size(), nxt);
                if (scan_crep + 1 < cs) begin
                    scan_crep++;
                end else begin
                    scan_crep = '0;
                    if (scan_col + 1 < cols) begin
                        scan_col++;
                    end else begin
                        scan_col = '0;
                        if (scan_rrep + 1 < rs) begin
                            scan_rrep++;
                        end else begin
                            scan_rrep = '0;
                            scan_row  = (scan_row + 1 < rows) ? scan_row + 6'd1 : '0;
                        end
                    end
                end
            end
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        t_out_pixel             got_pix, want_pix;
        logic [APB_DATA_W-1:0]  want_rd;
        if (!i_rst_n) begin
            rows_reg   = CFG_DIM_W'(1);
            cols_reg   = CFG_DIM_W'(1);
            rscale_reg = CFG_SCALE_W'(1);
            cscale_reg = CFG_SCALE_W'(1);
            ld_row     = '0;
            ld_col     = '0;
            scan_row   = '0;
            scan_rrep  = '0;
            scan_col   = '0;
            scan_crep  = '0;
            pixel_expect_q.delete();
        end else begin
            if (i_psel && i_penable && i_pready) begin
                if (i_pwrite) begin
                    case (t_reg_idx'(i_paddr[APB_ADDR_W-1:2]))
                        REG_IMAGE_ROWS: rows_reg   = i_pwdata[CFG_DIM_W-1:0];
                        REG_IMAGE_COLS: cols_reg   = i_pwdata[CFG_DIM_W-1:0];
                        REG_ROW_SCALE:  rscale_reg = i_pwdata[CFG_SCALE_W-1:0];
                        REG_COL_SCALE:  cscale_reg = i_pwdata[CFG_SCALE_W-1:0];
                        default: ;
                    endcase
                end else begin
                    want_rd = '0;
                    case (t_reg_idx'(i_paddr[APB_ADDR_W-1:2]))
                        REG_IMAGE_ROWS: want_rd[CFG_DIM_W-1:0]   = rows_reg;
                        REG_IMAGE_COLS: want_rd[CFG_DIM_W-1:0]   = cols_reg;
                        REG_ROW_SCALE:  want_rd[CFG_SCALE_W-1:0] = rscale_reg;
                        REG_COL_SCALE:  want_rd[CFG_SCALE_W-1:0] = cscale_reg;
                        default: ;
                    endcase
                    if (i_prdata !== want_rd)
                        flag_error($sformatf("readback at %0h: expected %0h, got %0h",
                                             i_paddr, want_rd, i_prdata));
                end
            end

            // results first, so a pull taken on this edge cannot match itself
            if (i_res_mon.valid && i_res_mon.ready) begin
                got_pix = {i_res_mon.pixel_out, i_res_mon.line_end, i_res_mon.frame_end};
                pixel_count++;
                if (got_pix.frame_end === 1'b1) frame_count++;
                if (pixel_expect_q.size() == 0) begin
                    flag_error($sformatf("unexpected pixel %02h line_end %0b frame_end %0b",
                                         got_pix.pixel, got_pix.line_end,
                                         got_pix.frame_end));
                end else begin
                    want_pix = pixel_expect_q.pop_front();
                    if (got_pix.pixel !== want_pix.pixel
                        || got_pix.line_end !== want_pix.line_end
                        || got_pix.frame_end !== want_pix.frame_end)
                        flag_error($sformatf({"pixel %0d: expected %02h/%0b/%0b, ",
                                              "got %02h/%0b/%0b (pixel/line_end/frame_end)"},
                                             pixel_count, want_pix.pixel,
                                             want_pix.line_end, want_pix.frame_end,
                                             got_pix.pixel, got_pix.line_end,
                                             got_pix.frame_end));
                end
            end

            if (i_pix_mon.valid && i_pix_mon.ready)
                upscale_step(t_command'(i_pix_mon.command), i_pix_mon.pixel_in);
        end
        o_pending    <= pixel_expect_q.size();
        o_mismatches <= mismatch_count;
        o_pixels     <= pixel_count;
        o_frames     <= frame_count;
    end

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives load, pull and restart commands plus register settings into the
// pixel replication upscaler; a checker beside it predicts and compares every
// output pixel with its line and frame flags.
// ----------------------------------------------------------------------------

module testbench;
    import ipru_pkg::*;

    localparam int CLK_HALF_NS     = 5;
    localparam int RESET_CYCLES    = 10;
    localparam int ITEM_TARGET     = 1050;
    localparam int DRAIN_CYCLES    = 10;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int FLUSH_LIMIT     = 20000;
    localparam int WATCHDOG_NS     = 3000000;
    localparam int GRID_ROWS       = 64;
    localparam int GRID_COLS       = 64;
    localparam int GRID_SCALE      = 16;

    // receiver behavior for one stretch of cycles
    typedef enum int {
        SINK_OPEN,
        SINK_RANDOM,
        SINK_SPARSE
    } t_sink_mode;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    ipru_in_if  pix_if();
    ipru_out_if res_if();

    // checker status
    int mismatches;
    int pending;
    int pixels_seen;
    int frames_seen;

    // Stimulus-side view of the load position and of which frame store
    // entries hold data; pulls are only issued once the whole current
    // image region has been written at least once.
    int cfg_rows;
    int cfg_cols;
    int ld_row;
    int ld_col;
    bit written [GRID_ROWS*GRID_COLS];

    int accepted_items;     // transfers that do something (no idle commands)
    int settings_used;
    int burst_left;
    int hold_off_asked;     // bumped by the stimulus
    int hold_off_done;      // bumped by the receiver

    always #CLK_HALF_NS i_clk = ~i_clk;

    integer_pixel_replication_upscaler DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_pix   (pix_if),
        .o_res   (res_if)
    );

    upscale_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_prdata     (prdata),
        .i_pix_mon    (pix_if),
        .i_res_mon    (res_if),
        .o_mismatches (mismatches),
        .o_pending    (pending),
        .o_pixels     (pixels_seen),
        .o_frames     (frames_seen)
    );

    function automatic int fit_range(input int v, input int hi);
        if (v == 0) return 1;
        return (v > hi) ? hi : v;
    endfunction

    // true when every entry of the current image region has been loaded
    function automatic bit region_safe();
        for (int r = 0; r < cfg_rows; r++)
            for (int c = 0; c < cfg_cols; c++)
                if (!written[r*GRID_COLS + c]) return 1'b0;
        return 1'b1;
    endfunction

    // mostly small images, some zero (acts as 1) and some past the maximum
    function automatic int pick_dim();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return 0;
        if (r < 22) return $urandom_range(33, 127);
        return $urandom_range(1, 8);
    endfunction

    function automatic int pick_scale();
        int r;
        r = $urandom_range(0, 99);
        if (r < 12) return 0;
        if (r < 27) return $urandom_range(16, 31);
        if (r < 40) return $urandom_range(5, 15);
        return $urandom_range(1, 4);
    endfunction

    // One APB transfer: setup phase, then access phase until pready.
    // An idle wait at the end keeps back-to-back calls from stacking
    // two assignments on psel in one step.
    task automatic reg_access(input bit is_write, input t_reg_idx idx,
                              input logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do begin
            @(posedge i_clk);
        end while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // Writes all four registers (upper data bits random, the block ignores
    // them), reads them back, and updates the stimulus-side image size.
    task automatic apply_setting(input int rows_v, input int cols_v,
                                 input int rs_v, input int cs_v);
        logic [APB_DATA_W-1:0] word;
        word = $urandom;
        word[CFG_DIM_W-1:0] = rows_v[CFG_DIM_W-1:0];
        reg_access(1'b1, REG_IMAGE_ROWS, word);
        word = $urandom;
        word[CFG_DIM_W-1:0] = cols_v[CFG_DIM_W-1:0];
        reg_access(1'b1, REG_IMAGE_COLS, word);
        word = $urandom;
        word[CFG_SCALE_W-1:0] = rs_v[CFG_SCALE_W-1:0];
        reg_access(1'b1, REG_ROW_SCALE, word);
        word = $urandom;
        word[CFG_SCALE_W-1:0] = cs_v[CFG_SCALE_W-1:0];
        reg_access(1'b1, REG_COL_SCALE, word);
        for (int i = 0; i < 4; i++)
            reg_access(1'b0, t_reg_idx'(i), '0);
        cfg_rows = fit_range(rows_v & 'h7f, GRID_ROWS);
        cfg_cols = fit_range(cols_v & 'h7f, GRID_COLS);
        settings_used++;
    endtask

    // Offers one command until the block takes it, tracks the load side,
    // then applies the sender's burst/gap pacing.
    task automatic push_item(input t_command cmd, input logic [PIXEL_W-1:0] pix);
        int gap;
        pix_if.valid    <= 1'b1;
        pix_if.command  <= cmd;
        pix_if.pixel_in <= pix;
        do begin
            @(posedge i_clk);
        end while (!pix_if.ready);

        case (cmd)
            CMD_LOAD: begin
                // loads past the last image row are dropped by the block
                if (ld_row < cfg_rows) begin
                    if (ld_col >= cfg_cols) ld_col = 0;
                    written[ld_row*GRID_COLS + ld_col] = 1'b1;
                    if (ld_col + 1 >= cfg_cols) begin
                        ld_col = 0;
                        ld_row++;
                    end else begin
                        ld_col++;
                    end
                    accepted_items++;
                end
            end
            CMD_RESTART: begin
                ld_row = 0;
                ld_col = 0;
                accepted_items++;
            end
            CMD_PULL: accepted_items++;
            default: ;
        endcase

        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 32);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                pix_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // Block idle: nothing offered, every predicted pixel delivered, and a
    // DRAIN_CYCLES wait for a trailing load to retire before registers change.
    task automatic settle();
        pix_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // One register setting followed by a random command mix. While the
    // image is still loading the mix is mostly loads; once it is in,
    // mostly pulls. Restarts, idle commands, surplus loads and early pulls
    // over older data make up the broken part.
    task automatic run_phase(input int rows_v, input int cols_v,
                             input int rs_v, input int cs_v);
        int       budget;
        int       r;
        t_command cmd;
        apply_setting(rows_v, cols_v, rs_v, cs_v);
        budget = $urandom_range(40, 100) + cfg_rows * cfg_cols;
        repeat (budget) begin
            r = $urandom_range(0, 99);
            if (ld_row < cfg_rows)
                cmd = (r < 88) ? CMD_LOAD : (r < 93) ? CMD_PULL :
                      (r < 97) ? CMD_NOP : CMD_RESTART;
            else
                cmd = (r < 84) ? CMD_PULL : (r < 89) ? CMD_LOAD :
                      (r < 93) ? CMD_NOP : CMD_RESTART;
            // never read a frame store entry that was never loaded
            if (cmd == CMD_PULL && !region_safe())
                cmd = (ld_row < cfg_rows) ? CMD_LOAD : CMD_RESTART;
            push_item(cmd, PIXEL_W'($urandom));
        end
        settle();
    endtask

    // Receiver: random stretches of open, random and sparse ready, plus a
    // long hold-off whenever the stimulus asks for one.
    initial begin : result_sink
        t_sink_mode mode;
        int         stretch;
        res_if.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (hold_off_asked > hold_off_done) begin
                res_if.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
                hold_off_done++;
            end else begin
                mode    = t_sink_mode'($urandom_range(0, 2));
                stretch = $urandom_range(1, 40);
                for (int k = 0; k < stretch && hold_off_asked == hold_off_done; k++) begin
                    case (mode)
                        SINK_OPEN:   res_if.ready <= 1'b1;
                        SINK_RANDOM: res_if.ready <= 1'($urandom_range(0, 1));
                        default:     res_if.ready <= ($urandom_range(0, 3) == 0);
                    endcase
                    @(posedge i_clk);
                end
            end
        end
    end

    initial begin : stimulus
        int rows_v;
        int cols_v;
        int leftover;
        int wait_cycles;

        // every input known from time zero
        i_rst_n         = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        pix_if.valid    = 1'b0;
        pix_if.command  = CMD_NOP;
        pix_if.pixel_in = '0;
        cfg_rows        = 1;
        cfg_cols        = 1;
        ld_row          = 0;
        ld_col          = 0;
        burst_left      = 1;
        accepted_items  = 0;
        settings_used   = 0;
        hold_off_asked  = 0;
        hold_off_done   = 0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // registers come out of reset at 1
        for (int i = 0; i < 4; i++)
            reg_access(1'b0, t_reg_idx'(i), '0);

        // Directed: 1x1 image at reset setting. Pixel extremes, a load past
        // the image, every pull ending both line and frame, wrap to the
        // first pixel, idle command, restart and reload.
        push_item(CMD_LOAD, 8'h00);
        push_item(CMD_LOAD, 8'hff);
        push_item(CMD_PULL, 8'h5a);
        push_item(CMD_PULL, 8'ha5);
        push_item(CMD_NOP, 8'hff);
        push_item(CMD_RESTART, 8'h00);
        push_item(CMD_LOAD, 8'hff);
        push_item(CMD_PULL, 8'h00);
        settle();

        // 2x2 image, rows doubled: stop three quarters through the frame
        apply_setting(2, 2, 2, 1);
        push_item(CMD_RESTART, PIXEL_W'($urandom));
        repeat (4) push_item(CMD_LOAD, PIXEL_W'($urandom));
        repeat (6) push_item(CMD_PULL, PIXEL_W'($urandom));
        settle();

        // Shrink without restart: the scan row and row repeat now sit past
        // their limits and fall back to zero, the load position is past
        // the image so loads would be dropped.
        apply_setting(1, 2, 1, 1);
        repeat (3) push_item(CMD_PULL, PIXEL_W'($urandom));

        // Backpressure: receiver holds off while pulls keep coming, so the
        // result register fills and the command input stalls.
        hold_off_asked++;
        repeat (40) push_item(CMD_PULL, PIXEL_W'($urandom));
        settle();

        // Random part, opening with the register extremes.
        run_phase(127, 3, 31, 0);   // tallest image, deepest row repeat
        run_phase(0, 64, 0, 16);    // widest image, widest pixel repeat
        run_phase(64, 1, 16, 16);   // exact maxima
        while (accepted_items < ITEM_TARGET) begin
            rows_v = pick_dim();
            cols_v = pick_dim();
            if (fit_range(rows_v, GRID_ROWS) * fit_range(cols_v, GRID_COLS) > 256)
                cols_v = $urandom_range(1, 4);
            run_phase(rows_v, cols_v, pick_scale(), pick_scale());
        end

        // drain with a bound, then let trailing activity settle
        pix_if.valid <= 1'b0;
        for (wait_cycles = 0; pending != 0 && wait_cycles < FLUSH_LIMIT; wait_cycles++)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        leftover = pending;
        if (leftover != 0)
            $display("tb: %0d predicted pixels never arrived", leftover);

        $display("tb: %0d command transfers over %0d register settings",
                 accepted_items, settings_used);
        $display("tb: %0d output pixels checked, %0d frame ends, %0d mismatches",
                 pixels_seen, frames_seen, mismatches);
        if (mismatches == 0 && leftover == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // hard stop if a handshake never completes
    initial begin : watchdog
        #WATCHDOG_NS;
        $display("tb: failure");
        $finish;
    end

endmodule
